/* hw/rtl/rigid_body_rotation_derivative_assert.svh */
// ----------------------------------------------------------------------------
// rigid body rotation derivative assertion macros
// property templates shared by the checker, clocked on i_clk with i_rst_n
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_ROTATION_DERIVATIVE_ASSERT_SVH
`define RIGID_BODY_ROTATION_DERIVATIVE_ASSERT_SVH

// antecedent implies consequent, disabled in reset
`define RBRD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("rbrd assertion failed");

// expression never true out of reset
`define RBRD_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("rbrd assertion failed");

`endif

/* hw/rtl/rbrd_pkg.sv */
// ----------------------------------------------------------------------------
// rbrd_pkg
// widths, types and the floor shift with saturation for the rigid body
// rotation derivative datapath
// ----------------------------------------------------------------------------
package rbrd_pkg;

    localparam int FRAC_BITS = 20;
    localparam int VAL_W     = 40;
    localparam int HALF_W    = VAL_W / 2;
    localparam int PLO_W     = VAL_W + HALF_W + 1;
    localparam int PHI_W     = 2 * VAL_W - HALF_W;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int N_IN      = 12;
    localparam int N_AX      = 9;
    localparam int PIPE_D    = 6;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic [1:0] {
        CFG_ROLL  = 2'd0,
        CFG_PITCH = 2'd1,
        CFG_YAW   = 2'd2
    } t_cfg_idx;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic t_val scale_sat(input t_sum x);
        t_sum                  sh;
        logic [SUM_W-VAL_W:0]  hi;
        sh = x >>> FRAC_BITS;
        hi = sh[SUM_W-1:VAL_W-1];
        if ((&hi) || !(|hi)) begin
            return sh[VAL_W-1:0];
        end else if (sh[SUM_W-1]) begin
            return VAL_MIN;
        end else begin
            return VAL_MAX;
        end
    endfunction

endpackage

/* hw/rtl/rbrd_mul.sv */
// ----------------------------------------------------------------------------
// rbrd_mul
// two-stage exact signed multiplier, one operand split into halves
// ----------------------------------------------------------------------------
module rbrd_mul (
    input  logic           i_clk,
    input  rbrd_pkg::t_val i_a,
    input  rbrd_pkg::t_val i_b,
    output rbrd_pkg::t_prod o_p
);

    logic signed [rbrd_pkg::HALF_W:0]                  b_lo;
    logic signed [rbrd_pkg::VAL_W-rbrd_pkg::HALF_W-1:0] b_hi;
    logic signed [rbrd_pkg::PLO_W-1:0]                 r_lo;
    logic signed [rbrd_pkg::PHI_W-1:0]                 r_hi;
    rbrd_pkg::t_prod                                   r_p;

    assign b_lo = $signed({1'b0, i_b[rbrd_pkg::HALF_W-1:0]});
    assign b_hi = i_b[rbrd_pkg::VAL_W-1:rbrd_pkg::HALF_W];

    always_ff @(posedge i_clk) begin
        r_lo <= (rbrd_pkg::PLO_W)'(i_a) * (rbrd_pkg::PLO_W)'(b_lo);
        r_hi <= (rbrd_pkg::PHI_W)'(i_a) * (rbrd_pkg::PHI_W)'(b_hi);
        r_p  <= (rbrd_pkg::t_prod'(r_hi) <<< rbrd_pkg::HALF_W) + rbrd_pkg::t_prod'(r_lo);
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/rigid_body_rotation_derivative.sv */
// ----------------------------------------------------------------------------
// rigid_body_rotation_derivative
// a transaction passes the input registers, the first multiplier bank, the sum stage,
// the second multiplier bank and the registered output sums before reaching the result ports
// throughput: one transaction per cycle, busy stays low, the receiver cannot stall
// depth is set by two banks of two-stage multipliers with a sum stage after each
// reset clears the coefficients and the valid pipeline
// ----------------------------------------------------------------------------
module rigid_body_rotation_derivative (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  rbrd_pkg::t_val i_cfg_data,
    input  rbrd_pkg::t_val i_rate_p,
    input  rbrd_pkg::t_val i_rate_q,
    input  rbrd_pkg::t_val i_rate_r,
    input  rbrd_pkg::t_val i_axis1_x,
    input  rbrd_pkg::t_val i_axis1_y,
    input  rbrd_pkg::t_val i_axis1_z,
    input  rbrd_pkg::t_val i_axis2_x,
    input  rbrd_pkg::t_val i_axis2_y,
    input  rbrd_pkg::t_val i_axis2_z,
    input  rbrd_pkg::t_val i_axis3_x,
    input  rbrd_pkg::t_val i_axis3_y,
    input  rbrd_pkg::t_val i_axis3_z,
    output logic           o_valid,
    output rbrd_pkg::t_val o_drate_p,
    output rbrd_pkg::t_val o_drate_q,
    output rbrd_pkg::t_val o_drate_r,
    output rbrd_pkg::t_val o_daxis1_x,
    output rbrd_pkg::t_val o_daxis1_y,
    output rbrd_pkg::t_val o_daxis1_z,
    output rbrd_pkg::t_val o_daxis2_x,
    output rbrd_pkg::t_val o_daxis2_y,
    output rbrd_pkg::t_val o_daxis2_z,
    output rbrd_pkg::t_val o_daxis3_x,
    output rbrd_pkg::t_val o_daxis3_y,
    output rbrd_pkg::t_val o_daxis3_z
);

    logic                          accept;
    rbrd_pkg::t_val                r_coef [3];
    rbrd_pkg::t_val                n_in   [rbrd_pkg::N_IN];
    rbrd_pkg::t_val                r_in   [rbrd_pkg::N_IN];
    rbrd_pkg::t_val                r_ax1  [rbrd_pkg::N_AX];
    rbrd_pkg::t_val                r_ax2  [rbrd_pkg::N_AX];
    rbrd_pkg::t_val                r_ax3  [rbrd_pkg::N_AX];
    rbrd_pkg::t_val                r_rp   [3];
    rbrd_pkg::t_val                r_w    [3];
    rbrd_pkg::t_val                m1_a   [12];
    rbrd_pkg::t_val                m1_b   [12];
    rbrd_pkg::t_prod               m1_p   [12];
    rbrd_pkg::t_val                m2_a   [21];
    rbrd_pkg::t_val                m2_b   [21];
    rbrd_pkg::t_prod               m2_p   [21];
    rbrd_pkg::t_val                n_out  [rbrd_pkg::N_IN];
    rbrd_pkg::t_val                r_out  [rbrd_pkg::N_IN];
    logic [rbrd_pkg::PIPE_D-1:0]   r_vld;
    logic                          r_o_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbrd_pkg::CFG_ROLL:  r_coef[0] <= i_cfg_data;
                rbrd_pkg::CFG_PITCH: r_coef[1] <= i_cfg_data;
                rbrd_pkg::CFG_YAW:   r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_in[0]  = i_rate_p;
        n_in[1]  = i_rate_q;
        n_in[2]  = i_rate_r;
        n_in[3]  = i_axis1_x;
        n_in[4]  = i_axis1_y;
        n_in[5]  = i_axis1_z;
        n_in[6]  = i_axis2_x;
        n_in[7]  = i_axis2_y;
        n_in[8]  = i_axis2_z;
        n_in[9]  = i_axis3_x;
        n_in[10] = i_axis3_y;
        n_in[11] = i_axis3_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_vld     <= {r_vld[rbrd_pkg::PIPE_D-2:0], accept};
            r_o_valid <= r_vld[rbrd_pkg::PIPE_D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= n_in;
        end
        for (int k = 0; k < rbrd_pkg::N_AX; k++) begin
            r_ax1[k] <= r_in[3+k];
        end
        r_ax2 <= r_ax1;
        r_ax3 <= r_ax2;
    end

    // rate products and angular velocity terms
    for (genvar k = 0; k < 3; k++) begin : g_rp_ops
        assign m1_a[k] = r_in[(k+1)%3];
        assign m1_b[k] = r_in[(k+2)%3];
    end

    for (genvar i = 0; i < 3; i++) begin : g_w_comp
        for (genvar j = 0; j < 3; j++) begin : g_w_term
            assign m1_a[3+3*i+j] = r_in[j];
            assign m1_b[3+3*i+j] = r_in[3+3*j+i];
        end
    end

    for (genvar g = 0; g < 12; g++) begin : g_bank1
        rbrd_mul u_mul (
            .i_clk (i_clk),
            .i_a   (m1_a[g]),
            .i_b   (m1_b[g]),
            .o_p   (m1_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_rp[k] <= rbrd_pkg::scale_sat(rbrd_pkg::t_sum'(m1_p[k]));
            r_w[k]  <= rbrd_pkg::scale_sat(rbrd_pkg::t_sum'(m1_p[3+3*k])
                                         + rbrd_pkg::t_sum'(m1_p[4+3*k])
                                         + rbrd_pkg::t_sum'(m1_p[5+3*k]));
        end
    end

    // coefficient products and cross product terms
    for (genvar k = 0; k < 3; k++) begin : g_cf_ops
        assign m2_a[k] = r_coef[k];
        assign m2_b[k] = r_rp[k];
    end

    for (genvar kk = 0; kk < 3; kk++) begin : g_cx_axis
        for (genvar c = 0; c < 3; c++) begin : g_cx_comp
            localparam int IDX = 3 + 2 * (3 * kk + c);
            assign m2_a[IDX]   = r_w[(c+1)%3];
            assign m2_b[IDX]   = r_ax3[3*kk+(c+2)%3];
            assign m2_a[IDX+1] = r_w[(c+2)%3];
            assign m2_b[IDX+1] = r_ax3[3*kk+(c+1)%3];
        end
    end

    for (genvar g = 0; g < 21; g++) begin : g_bank2
        rbrd_mul u_mul (
            .i_clk (i_clk),
            .i_a   (m2_a[g]),
            .i_b   (m2_b[g]),
            .o_p   (m2_p[g])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out[k] = rbrd_pkg::scale_sat(rbrd_pkg::t_sum'(m2_p[k]));
        end
        for (int n = 0; n < rbrd_pkg::N_AX; n++) begin
            n_out[3+n] = rbrd_pkg::scale_sat(rbrd_pkg::t_sum'(m2_p[3+2*n])
                                           - rbrd_pkg::t_sum'(m2_p[4+2*n]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[rbrd_pkg::PIPE_D-1]) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_drate_p  = r_out[0];
    assign o_drate_q  = r_out[1];
    assign o_drate_r  = r_out[2];
    assign o_daxis1_x = r_out[3];
    assign o_daxis1_y = r_out[4];
    assign o_daxis1_z = r_out[5];
    assign o_daxis2_x = r_out[6];
    assign o_daxis2_y = r_out[7];
    assign o_daxis2_z = r_out[8];
    assign o_daxis3_x = r_out[9];
    assign o_daxis3_y = r_out[10];
    assign o_daxis3_z = r_out[11];

endmodule

/* hw/rtl/rbrd_chk.sv */
// ----------------------------------------------------------------------------
// rbrd_chk
// port-level checks on transaction timing and zero-rate results, bound to the top
// ----------------------------------------------------------------------------
`include "rigid_body_rotation_derivative_assert.svh"

module rbrd_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input rbrd_pkg::t_val i_rate_p,
    input rbrd_pkg::t_val i_rate_q,
    input rbrd_pkg::t_val o_drate_p,
    input rbrd_pkg::t_val o_drate_r
);

    `RBRD_ASSERT_NEVER(a_busy_low, busy)
    `RBRD_ASSERT_IMPL(a_result_follows, start && !busy, ##7 o_valid)
    `RBRD_ASSERT_IMPL(a_result_has_source, o_valid, $past(start && !busy, 7))
    `RBRD_ASSERT_IMPL(a_zero_q_roll, o_valid && $past(i_rate_q == '0, 7), o_drate_p == '0)
    `RBRD_ASSERT_IMPL(a_zero_p_yaw, o_valid && $past(i_rate_p == '0, 7), o_drate_r == '0)

endmodule

bind rigid_body_rotation_derivative rbrd_chk u_rbrd_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .i_rate_p  (i_rate_p),
    .i_rate_q  (i_rate_q),
    .o_drate_p (o_drate_p),
    .o_drate_r (o_drate_r)
);
